@@ src/skt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  localparam int KEY_W       = 64;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 6;
  localparam int CNT_OUT_W   = 7;
  localparam int DEPTH_DEF   = 64;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEW  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value_in;
  } in_word_t;

  typedef struct packed {
    status_t               status;
    logic [POS_W-1:0]      position;
    logic [VAL_W-1:0]      value_out;
    logic [CNT_OUT_W-1:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic load_flags;
    logic shift_up;
    logic shift_down;
    logic overwrite;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/sorted_key_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  ports                        dir  payload
// in       in_valid, in_stall, in_data  in   skt_pkg::in_word_t
// out      out_valid, out_stall, out_data out skt_pkg::out_word_t
//
// each word is handled in two steps: accepting it loads the compare flags in every cell,
// then a later step shifts the row and registers the result word
// the next word is taken right after, while an earlier result may still wait
// while a stalled result holds the output register, the shift step waits until it frees
// reset clears the entry count and the busy flag; cell contents stay as they are

module sorted_key_table #(
  parameter int TABLE_DEPTH = skt_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire skt_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output skt_pkg::out_word_t      out_data
);

  localparam int CntW    = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW    = $clog2(TABLE_DEPTH);
  localparam int PosW    = skt_pkg::POS_W;
  localparam int CntOutW = skt_pkg::CNT_OUT_W;

  logic                      busy_r, busy_nxt;
  logic [CntW-1:0]           count_r, count_nxt;
  skt_pkg::cmd_t             cmd_r;
  logic [skt_pkg::KEY_W-1:0] key_r;
  logic [skt_pkg::VAL_W-1:0] val_r;
  logic                      out_valid_r, out_valid_nxt;
  skt_pkg::out_word_t        out_data_r, out_data_nxt;

  logic                      accept;
  logic                      exec;
  logic                      hit;
  logic                      full;
  logic                      ins_new;
  logic                      del_hit;
  logic [IdxW-1:0]           pos;
  logic [skt_pkg::VAL_W-1:0] hit_val;
  skt_pkg::cell_ctl_t        ctl;

  logic [skt_pkg::KEY_W-1:0] cell_key [TABLE_DEPTH];
  logic [skt_pkg::VAL_W-1:0] cell_val [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]    cell_lt;
  logic [TABLE_DEPTH-1:0]    cell_eq;
  logic [TABLE_DEPTH-1:0]    mark;

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign exec     = busy_r && (!out_valid_r || !out_stall);

  assign hit     = |cell_eq;
  assign full    = count_r >= CntW'(TABLE_DEPTH);
  assign ins_new = (cmd_r == skt_pkg::CMD_INSERT) && !hit && !full;
  assign del_hit = (cmd_r == skt_pkg::CMD_DELETE) && hit;

  assign ctl.load_flags = accept;
  assign ctl.shift_up   = exec && ins_new;
  assign ctl.shift_down = exec && del_hit;
  assign ctl.overwrite  = exec && (cmd_r == skt_pkg::CMD_INSERT) && hit;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic                      l_lt;
      logic [skt_pkg::KEY_W-1:0] l_key;
      logic [skt_pkg::VAL_W-1:0] l_val;
      logic [skt_pkg::KEY_W-1:0] r_key;
      logic [skt_pkg::VAL_W-1:0] r_val;

      if (g == 0) begin : g_first
        assign l_lt  = 1'b1;
        assign l_key = key_r;
        assign l_val = val_r;
        assign mark[g] = !cell_lt[g];
      end else begin : g_mid
        assign l_lt  = cell_lt[g-1];
        assign l_key = cell_key[g-1];
        assign l_val = cell_val[g-1];
        assign mark[g] = !cell_lt[g] && cell_lt[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_last
        assign r_key = cell_key[g];
        assign r_val = cell_val[g];
      end else begin : g_inner
        assign r_key = cell_key[g+1];
        assign r_val = cell_val[g+1];
      end

      skt_cell #(
        .IDX   (g),
        .CNT_W (CntW)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .probe_key (in_data.key),
        .count     (count_r),
        .new_key   (key_r),
        .new_val   (val_r),
        .left_lt   (l_lt),
        .left_key  (l_key),
        .left_val  (l_val),
        .right_key (r_key),
        .right_val (r_val),
        .key_o     (cell_key[g]),
        .val_o     (cell_val[g]),
        .lt_o      (cell_lt[g]),
        .eq_o      (cell_eq[g])
      );
    end
  endgenerate

  // first cell not below the key: slot of a hit or of a new entry
  always_comb begin
    pos     = '0;
    hit_val = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (mark[i]) begin
        pos = pos | IdxW'(i);
      end
      if (cell_eq[i]) begin
        hit_val = hit_val | cell_val[i];
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (exec) begin
      busy_nxt = 1'b0;
      if (ins_new) begin
        count_nxt = count_r + CntW'(1);
      end else if (del_hit) begin
        count_nxt = count_r - CntW'(1);
      end
      out_valid_nxt            = 1'b1;
      out_data_nxt.value_out   = '0;
      out_data_nxt.position    = '0;
      out_data_nxt.entry_count = CntOutW'(count_nxt);
      case (cmd_r)
        skt_pkg::CMD_INSERT: begin
          if (hit) begin
            out_data_nxt.status = skt_pkg::ST_OK;
          end else if (full) begin
            out_data_nxt.status = skt_pkg::ST_FULL;
          end else begin
            out_data_nxt.status = skt_pkg::ST_NEW;
          end
        end
        skt_pkg::CMD_DELETE: begin
          out_data_nxt.status = hit ? skt_pkg::ST_OK : skt_pkg::ST_MISS;
        end
        default: begin
          out_data_nxt.status = hit ? skt_pkg::ST_OK : skt_pkg::ST_MISS;
          if (hit) begin
            out_data_nxt.value_out = hit_val;
          end
        end
      endcase
      if (hit || ins_new) begin
        out_data_nxt.position = PosW'(pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      cmd_r <= in_data.command;
      key_r <= in_data.key;
      val_r <= in_data.value_in;
    end
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ src/skt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire skt_pkg::cell_ctl_t        ctl,
  input  wire logic [skt_pkg::KEY_W-1:0] probe_key,
  input  wire logic [CNT_W-1:0]          count,
  input  wire logic [skt_pkg::KEY_W-1:0] new_key,
  input  wire logic [skt_pkg::VAL_W-1:0] new_val,
  input  wire logic                      left_lt,
  input  wire logic [skt_pkg::KEY_W-1:0] left_key,
  input  wire logic [skt_pkg::VAL_W-1:0] left_val,
  input  wire logic [skt_pkg::KEY_W-1:0] right_key,
  input  wire logic [skt_pkg::VAL_W-1:0] right_val,
  output logic [skt_pkg::KEY_W-1:0]      key_o,
  output logic [skt_pkg::VAL_W-1:0]      val_o,
  output logic                           lt_o,
  output logic                           eq_o
);

  logic [skt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [skt_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                      lt_r, lt_nxt;
  logic                      eq_r, eq_nxt;
  logic                      held;

  assign held = CNT_W'(IDX) < count;

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    if (ctl.load_flags) begin
      lt_nxt = held && (key_r < probe_key);
      eq_nxt = held && (key_r == probe_key);
    end
    if (ctl.shift_up && !lt_r) begin
      if (left_lt) begin
        key_nxt = new_key;
        val_nxt = new_val;
      end else begin
        key_nxt = left_key;
        val_nxt = left_val;
      end
    end
    if (ctl.shift_down && !lt_r) begin
      key_nxt = right_key;
      val_nxt = right_val;
    end
    if (ctl.overwrite && eq_r) begin
      val_nxt = new_val;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  assign key_o = key_r;
  assign val_o = val_r;
  assign lt_o  = lt_r;
  assign eq_o  = eq_r;

endmodule

`default_nettype wire

@@ sim/sorted_key_table_tb.sv @@
`timescale 1ns / 1ps

module sorted_key_table_tb;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 12;

  class table_scoreboard;
    logic [skt_pkg::KEY_W-1:0] keys [skt_pkg::DEPTH_DEF];
    logic [skt_pkg::VAL_W-1:0] vals [skt_pkg::DEPTH_DEF];
    int held;
    int peak;
    int errors;
    int words_taken;
    int cmd_seen [4];
    int status_seen [4];
    skt_pkg::out_word_t awaited [$];

    function new();
      held = 0;
      peak = 0;
      errors = 0;
      words_taken = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // work out the reply to one accepted word and update the table copy
    function void note_word(skt_pkg::in_word_t w);
      skt_pkg::out_word_t r;
      int slot;
      bit hit;
      r = '0;
      slot = 0;
      while (slot < held && keys[slot] < w.key) slot++;
      hit = (slot < held) && (keys[slot] == w.key);
      case (w.command)
        skt_pkg::CMD_INSERT: begin
          if (hit) begin
            vals[slot] = w.value_in;
            r.status = skt_pkg::ST_OK;
            r.position = skt_pkg::POS_W'(slot);
          end else if (held >= skt_pkg::DEPTH_DEF) begin
            r.status = skt_pkg::ST_FULL;
          end else begin
            for (int i = held; i > slot; i--) begin
              keys[i] = keys[i-1];
              vals[i] = vals[i-1];
            end
            keys[slot] = w.key;
            vals[slot] = w.value_in;
            held++;
            r.status = skt_pkg::ST_NEW;
            r.position = skt_pkg::POS_W'(slot);
          end
        end
        skt_pkg::CMD_DELETE: begin
          if (hit) begin
            for (int i = slot; i + 1 < held; i++) begin
              keys[i] = keys[i+1];
              vals[i] = vals[i+1];
            end
            held--;
            r.status = skt_pkg::ST_OK;
            r.position = skt_pkg::POS_W'(slot);
          end else begin
            r.status = skt_pkg::ST_MISS;
          end
        end
        // the spare code behaves as a lookup
        default: begin
          if (hit) begin
            r.status = skt_pkg::ST_OK;
            r.position = skt_pkg::POS_W'(slot);
            r.value_out = vals[slot];
          end else begin
            r.status = skt_pkg::ST_MISS;
          end
        end
      endcase
      r.entry_count = skt_pkg::CNT_OUT_W'(held);
      if (held > peak) peak = held;
      words_taken++;
      cmd_seen[w.command]++;
      status_seen[r.status]++;
      awaited.push_back(r);
    endfunction

    function void report_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(skt_pkg::out_word_t got);
      skt_pkg::out_word_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      report_field("status", want.status, got.status);
      report_field("position", want.position, got.position);
      report_field("value_out", want.value_out, got.value_out);
      report_field("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  skt_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  skt_pkg::out_word_t out_data;

  bit gaps_on = 1'b1;
  int quiet_cycles = 0;
  table_scoreboard sb;

  sorted_key_table dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_reply(out_data);
    end
    out_stall <= gaps_on && ($urandom_range(0, 99) < 32);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic skt_pkg::in_word_t make_word(logic [1:0] code,
                                                  logic [skt_pkg::KEY_W-1:0] k,
                                                  logic [skt_pkg::VAL_W-1:0] v);
    skt_pkg::in_word_t w;
    w.command = skt_pkg::cmd_t'(code);
    w.key = k;
    w.value_in = v;
    return w;
  endfunction

  function automatic logic [skt_pkg::KEY_W-1:0] text_key();
    logic [skt_pkg::KEY_W-1:0] k;
    int len;
    k = '0;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      k[skt_pkg::KEY_W-1-8*i -: 8] = 8'($urandom_range(97, 122));
    end
    return k;
  endfunction

  function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
    logic [skt_pkg::KEY_W-1:0] k;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll >= 96) begin
      k = (roll[0]) ? '1 : '0;
    end else if (sb.held != 0 && roll < 45) begin
      k = sb.keys[$urandom_range(0, sb.held - 1)];
      // neighbours of held keys land between entries
      if (roll < 8) k = k + 1;
      else if (roll < 14) k = k - 1;
    end else if (roll < 70) begin
      k = text_key();
    end else begin
      k = {$urandom(), $urandom()};
    end
    return k;
  endfunction

  function automatic skt_pkg::in_word_t random_word(int ins_pct, int del_pct);
    skt_pkg::in_word_t w;
    int roll;
    roll = $urandom_range(0, 99);
    w.key = pick_key();
    w.value_in = $urandom();
    if (roll < 4) w.command = skt_pkg::cmd_t'(CMD_SPARE);
    else if (roll < 4 + ins_pct) w.command = skt_pkg::CMD_INSERT;
    else if (roll < 4 + ins_pct + del_pct) w.command = skt_pkg::CMD_DELETE;
    else w.command = skt_pkg::CMD_LOOKUP;
    return w;
  endfunction

  task automatic send_word(skt_pkg::in_word_t w);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  task automatic run_mix(int count, int ins_pct, int del_pct);
    for (int n = 0; n < count; n++) send_word(random_word(ins_pct, del_pct));
  endtask

  initial begin
    logic [skt_pkg::KEY_W-1:0] k_hello;
    logic [skt_pkg::KEY_W-1:0] k_apple;
    sb = new();
    k_hello = {"hello", 24'd0};
    k_apple = {"apple", 24'd0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, overwrite, spare code, delete at both ends
    send_word(make_word(skt_pkg::CMD_LOOKUP, '0, '0));
    send_word(make_word(skt_pkg::CMD_DELETE, '1, 32'hffff_ffff));
    send_word(make_word(skt_pkg::CMD_INSERT, k_hello, '0));
    send_word(make_word(skt_pkg::CMD_INSERT, '0, 32'hffff_ffff));
    send_word(make_word(skt_pkg::CMD_INSERT, '1, 32'h5555_5555));
    send_word(make_word(skt_pkg::CMD_INSERT, k_apple, 32'ha5a5_a5a5));
    send_word(make_word(skt_pkg::CMD_LOOKUP, '0, 32'hffff_ffff));
    send_word(make_word(skt_pkg::CMD_LOOKUP, '1, '0));
    send_word(make_word(skt_pkg::CMD_LOOKUP, k_hello, '0));
    send_word(make_word(skt_pkg::CMD_LOOKUP, k_hello + 1, '0));
    send_word(make_word(skt_pkg::CMD_INSERT, k_hello, 32'haaaa_aaaa));
    send_word(make_word(skt_pkg::CMD_LOOKUP, k_hello, 32'h1234_5678));
    send_word(make_word(CMD_SPARE, k_apple, 32'hffff_ffff));
    send_word(make_word(CMD_SPARE, k_apple - 1, '0));
    send_word(make_word(skt_pkg::CMD_DELETE, k_hello + 1, '0));
    send_word(make_word(skt_pkg::CMD_DELETE, k_hello, 32'hdead_beef));
    send_word(make_word(skt_pkg::CMD_LOOKUP, k_hello, '0));
    send_word(make_word(skt_pkg::CMD_DELETE, '0, '0));
    send_word(make_word(skt_pkg::CMD_DELETE, '1, '0));
    send_word(make_word(skt_pkg::CMD_LOOKUP, k_apple, '0));
    send_word(make_word(skt_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0001));
    send_word(make_word(skt_pkg::CMD_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h7fff_fffe));
    wait_drained();

    run_mix(170, 40, 25);
    wait_drained();

    // fill to capacity and hammer a full table, no idling on either side
    gaps_on = 1'b0;
    for (int n = 0; n < 200 && sb.held < skt_pkg::DEPTH_DEF; n++) begin
      send_word(make_word(skt_pkg::CMD_INSERT,
                          (n[0]) ? text_key() : {$urandom(), $urandom()},
                          $urandom()));
    end
    run_mix(60, 65, 5);
    gaps_on = 1'b1;
    wait_drained();

    run_mix(140, 15, 55);
    run_mix(90, 35, 30);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d lookups, %0d inserts, %0d deletes, %0d spare codes",
             sb.words_taken, sb.cmd_seen[skt_pkg::CMD_LOOKUP],
             sb.cmd_seen[skt_pkg::CMD_INSERT], sb.cmd_seen[skt_pkg::CMD_DELETE],
             sb.cmd_seen[CMD_SPARE]);
    $display("peak of %0d entries; %0d hits, %0d new, %0d misses, %0d dropped when full",
             sb.peak, sb.status_seen[skt_pkg::ST_OK], sb.status_seen[skt_pkg::ST_NEW],
             sb.status_seen[skt_pkg::ST_MISS], sb.status_seen[skt_pkg::ST_FULL]);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
